[src/sme_pkg.sv]
// shared types and constants for the sorted merge insert block
package sme_pkg;

    localparam int CAPACITY = 32;

    typedef struct packed {
        logic signed [31:0] value;
        logic               final_item;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] sorted_value;
        logic               last_out;
        logic               dropped;
    } t_out_item;

    typedef struct packed {
        logic               insert;
        logic               drain;
        logic signed [31:0] value;
    } t_cell_ctrl;

    // from cell i to cell i+1
    typedef struct packed {
        logic               valid;
        logic               take;
        logic signed [31:0] value;
    } t_fwd_link;

    // from cell i+1 to cell i
    typedef struct packed {
        logic               valid;
        logic signed [31:0] value;
    } t_bwd_link;

endpackage

[src/sme_cell.sv]
// one storage cell of the sorted insertion chain
module sme_cell
    import sme_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cell_ctrl i_ctrl,
    input  t_fwd_link  i_prev,
    input  t_bwd_link  i_next,
    output t_fwd_link  o_fwd,
    output t_bwd_link  o_bwd
);

    logic               r_valid;
    logic signed [31:0] r_value;
    logic               take;

    // new value goes after equal ones, so strict compare
    assign take = !r_valid || (i_ctrl.value < r_value);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.insert) begin
            r_valid <= r_valid | i_prev.valid;
        end else if (i_ctrl.drain) begin
            r_valid <= i_next.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.insert && take) begin
            // shift right if the left neighbor also moves, else capture the new value
            r_value <= i_prev.take ? i_prev.value : i_ctrl.value;
        end else if (i_ctrl.drain) begin
            r_value <= i_next.value;
        end
    end

    assign o_fwd.valid = r_valid;
    assign o_fwd.take  = take;
    assign o_fwd.value = r_value;
    assign o_bwd.valid = r_valid;
    assign o_bwd.value = r_value;

endmodule

[src/sorted_merge_insert.sv]
// top level of the sorted merge insert block
// Each accepted request inserts its value into a chain of CAPACITY cells kept in
// ascending signed order, one request per cycle while busy is low; the insert
// completes in the accept cycle. A request with final_item set is inserted and
// then the whole store drains out of cell 0, one result per cycle on o_strobe,
// during which busy is high. Results cannot be stalled. When the chain is full,
// further values are dropped and the dropped flag is reported on every result of
// that merge; the store and flag clear as the drain finishes.
module sorted_merge_insert
    import sme_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_in_item  i_req,
    output logic      busy,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_fwd_link  fwd [CAPACITY+1];
    t_bwd_link  bwd [CAPACITY+1];
    t_cell_ctrl ctrl;

    logic r_emit;
    logic r_ovf;
    logic accept;
    logic full;
    logic last;

    assign accept = start && !r_emit;
    assign full   = fwd[CAPACITY].valid;
    assign last   = !bwd[1].valid;

    assign ctrl.insert = accept && !full;
    assign ctrl.drain  = r_emit;
    assign ctrl.value  = i_req.value;

    // chain ends: the head always may take a slot, the tail feeds empties
    assign fwd[0].valid = 1'b1;
    assign fwd[0].take  = 1'b0;
    assign fwd[0].value = i_req.value;
    assign bwd[CAPACITY].valid = 1'b0;
    assign bwd[CAPACITY].value = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        sme_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl),
            .i_prev  (fwd[g]),
            .i_next  (bwd[g+1]),
            .o_fwd   (fwd[g+1]),
            .o_bwd   (bwd[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit <= 1'b0;
            r_ovf  <= 1'b0;
        end else if (r_emit) begin
            if (last) begin
                r_emit <= 1'b0;
                r_ovf  <= 1'b0;
            end
        end else if (accept) begin
            if (full) begin
                r_ovf <= 1'b1;
            end
            r_emit <= i_req.final_item;
        end
    end

    assign busy                  = r_emit;
    assign o_strobe              = r_emit;
    assign o_result.sorted_value = bwd[0].value;
    assign o_result.last_out     = last;
    assign o_result.dropped      = r_ovf;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the sorted merge insert block
module tb;
    import sme_pkg::*;

    localparam int MAX_EMIT    = 32;
    localparam int CYCLE_LIMIT = 200000;
    localparam int N_DIRECTED  = 16;
    localparam int N_RANDOM    = 454;
    localparam int QUIET_FROM  = 400;

    typedef enum int {VAL_WIDE, VAL_NARROW, VAL_EXTREME, VAL_RUNS} t_val_style;

    // keeps its own sorted store and the queue of values due on the next drain
    class merge_checker;
        logic signed [31:0] store [CAPACITY];
        int                 fill;
        bit                 overflow;
        t_out_item          pending_results [$];
        int                 n_requests;
        int                 n_results;
        int                 n_merges;
        int                 n_overflow_merges;
        int                 n_errors;

        task report_mismatch(string what);
            n_errors++;
            $display("mismatch: %s", what);
        endtask

        function void note_request(t_in_item req);
            int        pos;
            int        n;
            t_out_item res;
            n_requests++;
            if (fill >= CAPACITY) begin
                overflow = 1'b1;
            end else begin
                // equal values stay ahead of the new one
                pos = fill;
                while (pos > 0 && store[pos-1] > req.value) pos--;
                for (int k = fill; k > pos; k--) store[k] = store[k-1];
                store[pos] = req.value;
                fill++;
            end
            if (req.final_item) begin
                n = (fill > MAX_EMIT) ? MAX_EMIT : fill;
                for (int k = 0; k < n; k++) begin
                    res.sorted_value = store[k];
                    res.last_out     = (k == n - 1);
                    res.dropped      = overflow;
                    pending_results.push_back(res);
                end
                n_merges++;
                if (overflow) n_overflow_merges++;
                fill     = 0;
                overflow = 1'b0;
            end
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %0d", got.sorted_value));
                return;
            end
            want = pending_results.pop_front();
            if (got.sorted_value !== want.sorted_value)
                report_mismatch($sformatf("sorted_value %0d, expected %0d",
                                          got.sorted_value, want.sorted_value));
            if (got.last_out !== want.last_out)
                report_mismatch($sformatf("last_out %b, expected %b at value %0d",
                                          got.last_out, want.last_out, want.sorted_value));
            if (got.dropped !== want.dropped)
                report_mismatch($sformatf("dropped %b, expected %b at value %0d",
                                          got.dropped, want.dropped, want.sorted_value));
        endtask
    endclass

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_req   = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    merge_checker chk = new();
    int           items_sent  = 0;
    int           cycle_count = 0;
    bit           gaps_on     = 1'b0;

    sorted_merge_insert u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_req    (i_req),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb: FAIL");
            $finish;
        end
    end

    // results first: a request accepted on the same edge only adds later results
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(o_strobe) || $isunknown(busy))
                chk.report_mismatch("unknown value on o_strobe or busy");
            if (o_strobe === 1'b1) chk.check_result(o_result);
            if (start && busy === 1'b0) chk.note_request(i_req);
        end
    end

    task automatic send_request(logic signed [31:0] value, logic fin);
        int       gap;
        t_in_item req;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 19);
            start <= 1'b0;
            i_req <= t_in_item'({$urandom, 1'($urandom)});
            repeat (gap) @(posedge i_clk);
        end
        req.value      = value;
        req.final_item = fin;
        start <= 1'b1;
        i_req <= req;
        do @(posedge i_clk); while (busy !== 1'b0);
        items_sent++;
    endtask

    // interleaves a few ascending lists, or other value mixes, into one merge
    task automatic run_merge(int len, t_val_style style);
        logic signed [31:0] head [4];
        logic signed [31:0] v;
        int                 lanes;
        int                 lane;
        lanes = $urandom_range(2, 4);
        for (int i = 0; i < 4; i++) head[i] = $signed($urandom) >>> $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            case (style)
                VAL_WIDE: begin
                    v = $urandom;
                end
                VAL_NARROW: begin
                    v = $urandom_range(0, 6) - 3;
                end
                VAL_EXTREME: begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7fff_ffff;
                        2:       v = '0;
                        default: v = '1;
                    endcase
                end
                default: begin
                    lane = $urandom_range(0, lanes - 1);
                    head[lane] = head[lane] + $urandom_range(0, 500);
                    v = head[lane];
                end
            endcase
            send_request(v, i == len - 1);
        end
    endtask

    initial begin
        int len;
        bit first_full;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // a lone final item
        send_request('0, 1'b1);
        // both extremes, with a repeated minimum arriving last
        send_request(32'h7fff_ffff, 1'b0);
        send_request(32'h8000_0000, 1'b0);
        send_request('0, 1'b0);
        send_request('1, 1'b0);
        send_request(32'sd1, 1'b0);
        send_request(32'h8000_0000, 1'b1);
        // all equal
        send_request(32'sd5, 1'b0);
        send_request(32'sd5, 1'b0);
        send_request(32'sd5, 1'b0);
        send_request(32'sd5, 1'b1);
        // descending input
        send_request(32'sd3, 1'b0);
        send_request(32'sd2, 1'b0);
        send_request(32'sd1, 1'b0);
        send_request('0, 1'b1);
        send_request(32'h7fff_ffff, 1'b1);

        // first random merge overruns the store
        first_full = 1'b1;
        while (items_sent < N_DIRECTED + N_RANDOM) begin
            gaps_on = (items_sent < QUIET_FROM) && ($urandom_range(0, 2) != 0);
            if (first_full)
                len = CAPACITY + 4;
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(CAPACITY - 2, CAPACITY + 6);
            else
                len = $urandom_range(1, 12);
            first_full = 1'b0;
            run_merge(len, t_val_style'($urandom_range(0, 3)));
        end
        start <= 1'b0;

        while (chk.pending_results.size() != 0) @(posedge i_clk);
        repeat (CAPACITY + 8) @(posedge i_clk);

        $display("summary: %0d requests in %0d merges, %0d sorted values checked",
                 chk.n_requests, chk.n_merges, chk.n_results);
        $display("summary: %0d merges overran the store, %0d mismatches",
                 chk.n_overflow_merges, chk.n_errors);
        if (chk.n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
